[hw/rtl/tdq_pkg.sv]
// Shared types and constants of the timed deferral queue.
package tdq_pkg;

    localparam logic [1:0] ACT_SNOOZE   = 2'd0;
    localparam logic [1:0] ACT_TICK     = 2'd1;
    localparam logic [1:0] ACT_WAKE_ALL = 2'd2;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_RELEASED = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic [1:0] REG_MIN_DELAY  = 2'd0;
    localparam logic [1:0] REG_MAX_REPORT = 2'd1;

    localparam logic [15:0] MIN_DELAY_RESET  = 16'd1;
    localparam logic [15:0] MAX_REPORT_RESET = 16'd3600;

    localparam int MINUTE_BITS = 16;
    localparam int DELAY_BITS  = MINUTE_BITS + 6;
    localparam int COUNT_FIELD = 5;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

[hw/rtl/tdq_cell.sv]
// One storage cell of the queue chain: a wake time and a tag.
module tdq_cell #(
    parameter int TAG_BITS  = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                  aclk,
    input  tdq_pkg::cell_ctrl_t   ctrl,
    input  logic [TIME_BITS-1:0]  load_wake,
    input  logic [TAG_BITS-1:0]   load_tag,
    input  logic [TIME_BITS-1:0]  nbr_wake,
    input  logic [TAG_BITS-1:0]   nbr_tag,
    output logic [TIME_BITS-1:0]  wake,
    output logic [TAG_BITS-1:0]   tag
);

    logic [TIME_BITS-1:0] wake_reg;
    logic [TAG_BITS-1:0]  tag_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            wake_reg <= load_wake;
            tag_reg  <= load_tag;
        end else if (ctrl.shift) begin
            wake_reg <= nbr_wake;
            tag_reg  <= nbr_tag;
        end
    end

    assign wake = wake_reg;
    assign tag  = tag_reg;

endmodule

[hw/rtl/timed_deferral_queue.sv]
// Top level of the timed deferral queue: control, time keeping and the cell chain.
//
//  Channel   Side    Contents
//  s_        in      tuser: action; tdata: handle, minutes
//  m_        out     tuser: kind; tlast: last; tdata: handle, counts, empty, next wake
//  cfg_      in      register index and value, written at once
//
// A snooze passes through the snooze and finish states, then the output transfer. A tick or
// wake-all enters the sweep, where the chain steps its head out once per stored entry, then
// the finish state presents the final result.
// A stalled output holds the sweep whenever a release has to leave the block.
// Synchronous reset clears time and the entry count, restores the config, not the cells.
module timed_deferral_queue #(
    parameter int CAPACITY  = 16,
    parameter int TAG_BITS  = 16,
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // action
    input  logic [31:0] s_tdata,   // handle[15:0], minutes[31:16]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    // released_handle[15:0], released_count[20:16], held_count[25:21],
    // store_empty[26], next_wake_in[42:27], zero fill[47:43]
    output logic [47:0] m_tdata,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SNOOZE = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [15:0]          min_delay_reg, min_delay_next;
    logic [15:0]          max_report_reg, max_report_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     steps_reg, steps_next;
    logic [CNT_W-1:0]     rel_reg, rel_next;
    logic                 wake_all_reg, wake_all_next;
    logic                 kept_any_reg, kept_any_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [TAG_BITS-1:0]  pend_tag_reg, pend_tag_next;
    logic [TIME_BITS-1:0] min_wake_reg, min_wake_next;
    logic [1:0]           fin_kind_reg, fin_kind_next;
    logic [TAG_BITS-1:0]  handle_reg, handle_next;
    logic [15:0]          minutes_reg, minutes_next;
    logic [1:0]           m_kind_reg, m_kind_next;
    logic                 m_last_reg, m_last_next;
    logic [15:0]          m_handle_reg, m_handle_next;
    logic [4:0]           m_rel_reg, m_rel_next;
    logic [4:0]           m_held_reg, m_held_next;
    logic                 m_empty_reg, m_empty_next;
    logic [15:0]          m_wake_in_reg, m_wake_in_next;

    logic [TIME_BITS-1:0] cell_wake [CAPACITY];
    logic [TAG_BITS-1:0]  cell_tag  [CAPACITY];
    tdq_pkg::cell_ctrl_t  cell_ctrl [CAPACITY];

    logic                 load_en;
    logic [IDX_W-1:0]     load_idx;
    logic [TIME_BITS-1:0] load_wake;
    logic [TAG_BITS-1:0]  load_tag;
    logic                 shift_en;

    logic                 out_free;
    logic [15:0]          snz_minutes;
    logic [tdq_pkg::DELAY_BITS-1:0] snz_delay;
    logic [TIME_BITS:0]   snz_sum;
    logic [TIME_BITS-1:0] snz_wake;
    logic                 head_release;
    logic [TIME_BITS-1:0] wake_diff;
    logic [15:0]          wake_in;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign snz_minutes = (minutes_reg > min_delay_reg) ? minutes_reg : min_delay_reg;
    assign snz_delay   = {snz_minutes, 6'b0} - {4'b0, snz_minutes, 2'b0};
    assign snz_sum     = (TIME_BITS + 1)'(now_reg) + (TIME_BITS + 1)'(snz_delay);
    assign snz_wake    = snz_sum[TIME_BITS] ? '1 : snz_sum[TIME_BITS-1:0];

    assign head_release = wake_all_reg || (cell_wake[0] <= now_reg);

    assign wake_diff = (min_wake_reg > now_reg) ? (min_wake_reg - now_reg) : '0;
    assign wake_in   = (count_reg == '0) ? 16'd0 :
                       (wake_diff > TIME_BITS'(max_report_reg)) ? max_report_reg :
                       wake_diff[15:0];

    always_comb begin
        state_next      = state_reg;
        min_delay_next  = min_delay_reg;
        max_report_next = max_report_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        steps_next      = steps_reg;
        rel_next        = rel_reg;
        wake_all_next   = wake_all_reg;
        kept_any_next   = kept_any_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        min_wake_next   = min_wake_reg;
        fin_kind_next   = fin_kind_reg;
        handle_next     = handle_reg;
        minutes_next    = minutes_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;
        m_handle_next   = m_handle_reg;
        m_rel_next      = m_rel_reg;
        m_held_next     = m_held_reg;
        m_empty_next    = m_empty_reg;
        m_wake_in_next  = m_wake_in_reg;
        m_tvalid_next   = m_tready ? 1'b0 : m_tvalid_reg;
        load_en         = 1'b0;
        load_idx        = count_reg[IDX_W-1:0];
        load_wake       = snz_wake;
        load_tag        = handle_reg;
        shift_en        = 1'b0;

        if (cfg_we) begin
            if (cfg_addr == tdq_pkg::REG_MIN_DELAY) begin
                min_delay_next = cfg_wdata;
            end else if (cfg_addr == tdq_pkg::REG_MAX_REPORT) begin
                max_report_next = cfg_wdata;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    handle_next     = TAG_BITS'(s_tdata[15:0]);
                    minutes_next    = s_tdata[31:16];
                    rel_next        = '0;
                    steps_next      = count_reg;
                    kept_any_next   = 1'b0;
                    pend_valid_next = 1'b0;
                    wake_all_next   = (s_tuser == tdq_pkg::ACT_WAKE_ALL);
                    if (s_tuser == tdq_pkg::ACT_SNOOZE) begin
                        state_next = ST_SNOOZE;
                    end else if (s_tuser == tdq_pkg::ACT_TICK) begin
                        if (now_reg != '1) begin
                            now_next = now_reg + 1'b1;
                        end
                        state_next = ST_SWEEP;
                    end else if (s_tuser == tdq_pkg::ACT_WAKE_ALL) begin
                        state_next = ST_SWEEP;
                    end else begin
                        fin_kind_next   = tdq_pkg::KIND_NONE;
                        state_next      = ST_FINISH;
                    end
                end
            end
            ST_SNOOZE: begin
                if (count_reg >= CNT_W'(CAPACITY)) begin
                    fin_kind_next = tdq_pkg::KIND_REJECTED;
                end else begin
                    fin_kind_next = tdq_pkg::KIND_ACCEPTED;
                    load_en       = 1'b1;
                    count_next    = count_reg + 1'b1;
                    if (count_reg == '0 || snz_wake < min_wake_reg) begin
                        min_wake_next = snz_wake;
                    end
                end
                state_next = ST_FINISH;
            end
            ST_SWEEP: begin
                if (steps_reg == '0) begin
                    fin_kind_next = pend_valid_reg ? tdq_pkg::KIND_RELEASED
                                                   : tdq_pkg::KIND_NONE;
                    state_next    = ST_FINISH;
                end else if (!head_release || !pend_valid_reg || out_free) begin
                    shift_en   = 1'b1;
                    steps_next = steps_reg - 1'b1;
                    if (head_release) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next  = 1'b1;
                            m_kind_next    = tdq_pkg::KIND_RELEASED;
                            m_last_next    = 1'b0;
                            m_handle_next  = 16'(pend_tag_reg);
                            m_rel_next     = '0;
                            m_held_next    = '0;
                            m_empty_next   = 1'b0;
                            m_wake_in_next = '0;
                        end
                        pend_valid_next = 1'b1;
                        pend_tag_next   = cell_tag[0];
                        count_next      = count_reg - 1'b1;
                        rel_next        = rel_reg + 1'b1;
                    end else begin
                        load_en       = 1'b1;
                        load_idx      = IDX_W'(count_reg - 1'b1);
                        load_wake     = cell_wake[0];
                        load_tag      = cell_tag[0];
                        kept_any_next = 1'b1;
                        if (!kept_any_reg || cell_wake[0] < min_wake_reg) begin
                            min_wake_next = cell_wake[0];
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_kind_next    = fin_kind_reg;
                    m_last_next    = 1'b1;
                    m_handle_next  = (fin_kind_reg == tdq_pkg::KIND_RELEASED)
                                     ? 16'(pend_tag_reg) : 16'd0;
                    m_rel_next     = tdq_pkg::COUNT_FIELD'(rel_reg);
                    m_held_next    = tdq_pkg::COUNT_FIELD'(count_reg);
                    m_empty_next   = (count_reg == '0);
                    m_wake_in_next = wake_in;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            min_delay_reg  <= tdq_pkg::MIN_DELAY_RESET;
            max_report_reg <= tdq_pkg::MAX_REPORT_RESET;
            now_reg        <= '0;
            count_reg      <= '0;
            steps_reg      <= '0;
            rel_reg        <= '0;
            wake_all_reg   <= 1'b0;
            kept_any_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            min_delay_reg  <= min_delay_next;
            max_report_reg <= max_report_next;
            now_reg        <= now_next;
            count_reg      <= count_next;
            steps_reg      <= steps_next;
            rel_reg        <= rel_next;
            wake_all_reg   <= wake_all_next;
            kept_any_reg   <= kept_any_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_tag_reg  <= pend_tag_next;
        min_wake_reg  <= min_wake_next;
        fin_kind_reg  <= fin_kind_next;
        handle_reg    <= handle_next;
        minutes_reg   <= minutes_next;
        m_kind_reg    <= m_kind_next;
        m_last_reg    <= m_last_next;
        m_handle_reg  <= m_handle_next;
        m_rel_reg     <= m_rel_next;
        m_held_reg    <= m_held_next;
        m_empty_reg   <= m_empty_next;
        m_wake_in_reg <= m_wake_in_next;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [TIME_BITS-1:0] nbr_wake;
        logic [TAG_BITS-1:0]  nbr_tag;

        if (i == CAPACITY - 1) begin : g_tail
            assign nbr_wake = '0;
            assign nbr_tag  = '0;
        end else begin : g_body
            assign nbr_wake = cell_wake[i+1];
            assign nbr_tag  = cell_tag[i+1];
        end

        assign cell_ctrl[i].shift = shift_en;
        assign cell_ctrl[i].load  = load_en && (load_idx == IDX_W'(i));

        tdq_cell #(
            .TAG_BITS  (TAG_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .load_wake (load_wake),
            .load_tag  (load_tag),
            .nbr_wake  (nbr_wake),
            .nbr_tag   (nbr_tag),
            .wake      (cell_wake[i]),
            .tag       (cell_tag[i])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'b0, m_wake_in_reg, m_empty_reg, m_held_reg, m_rel_reg, m_handle_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (steps_reg <= count_reg))
        else $error("sweep steps exceed stored entries");

    a_rel_held: assert property (@(posedge aclk) disable iff (!aresetn)
        ((CNT_W + 1)'(rel_reg) + (CNT_W + 1)'(count_reg)) <= (CNT_W + 1)'(CAPACITY))
        else $error("released plus held entries exceed capacity");

    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (m_tvalid_reg && m_last_reg))
        else $error("final result not presented with last set");

endmodule
